>>> src/undo_log_rollback_assert.svh
// undo_log_rollback_assert.svh: assertion macros shared by the ulr modules.
// Depends on a clock named clk and an active-low reset named rst_n in the including module.
`ifndef UNDO_LOG_ROLLBACK_ASSERT_SVH
`define UNDO_LOG_ROLLBACK_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define ULR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ULR_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> src/ulr_pkg.sv
// ulr_pkg: types, command codes and defaults for the undo-log rollback block.
// No dependencies; imported by undo_log_rollback, ulr_ctrl and ulr_dpath.
package ulr_pkg;

    localparam int unsigned TXN_IDS_DEF     = 256;
    localparam int unsigned ITEM_COUNT_DEF  = 256;
    localparam int unsigned LOG_DEPTH_DEF   = 1024;
    localparam int unsigned VALUE_WIDTH_DEF = 32;

    localparam int unsigned CMD_W      = 3;
    localparam int unsigned ID_W       = 8;
    localparam int unsigned PORT_VAL_W = 32;
    localparam int unsigned PORT_CNT_W = 11;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_COMMIT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RECOVER = 3'd5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_REC_LOG,
        ST_REC_TXN,
        ST_REC_APPLY,
        ST_REC_CLEAR,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic capture;
        logic item_wr_req;
        logic item_wr_undo;
        logic item_wr_clear;
        logic txn_wr_start;
        logic txn_wr_commit;
        logic txn_wr_clear;
        logic txn_rd_log;
        logic log_push;
        logic rec_begin;
        logic rec_step;
        logic rec_count;
        logic sweep_all;
        logic sweep_txn;
        logic out_load_now;
        logic out_load_pend;
        logic pend_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             log_full;
        logic             log_empty;
        logic             txn_known;
        logic             txn_active;
        logic             rec_last;
        logic             sweep_last_all;
        logic             sweep_last_txn;
        logic             out_free;
    } dp_stat_t;

    // Reduce an identifier modulo m by shift-and-subtract, one bit a step.
    function automatic logic [ID_W-1:0] fold_index(input logic [ID_W-1:0] x,
                                                   input int unsigned m);
        logic [31:0] r;
        r = 32'(x);
        for (int k = ID_W - 1; k >= 0; k--)
        begin
            if (r >= (32'(m) << k))
            begin
                r = r - (32'(m) << k);
            end
        end
        return r[ID_W-1:0];
    endfunction

endpackage

>>> src/undo_log_rollback.sv
// undo_log_rollback: top level of the undo-log rollback block.
// Depends on ulr_pkg, ulr_ctrl, ulr_dpath and ulr_ram.
//
// Usage
//   Request channel: in_valid / in_stall with cmd, txn_id, item_index, write_value.
//   A request is taken on a rising edge with in_valid high and in_stall low.
//   Response channel: out_valid / out_stall with status, read_value, restored_count.
//   Exactly one response per request, in request order.
// Sequencing
//   Load, start, commit, read, write and unused codes: the response is registered
//   from the execute state after the request is taken; the next request is taken only
//   after that state, since the item store or transaction table is read ahead of its write.
//   Recover: each log entry takes a log read, a table lookup and an item restore,
//   then the table is swept clear.
// Reset
//   After rst_n rises, in_stall holds high while the item store and transaction
//   table are swept to zero. The log needs no sweep.
// Back-pressure
//   A finished response waits in the output register while out_stall is high; the
//   next request is still taken and its response is parked in a second register.
//   Once both are full, the sequencer holds with in_stall high until the output frees.
module undo_log_rollback #(
    parameter int unsigned TXN_IDS     = ulr_pkg::TXN_IDS_DEF,
    parameter int unsigned ITEM_COUNT  = ulr_pkg::ITEM_COUNT_DEF,
    parameter int unsigned LOG_DEPTH   = ulr_pkg::LOG_DEPTH_DEF,
    parameter int unsigned VALUE_WIDTH = ulr_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [ulr_pkg::CMD_W-1:0]              cmd,
    input  logic [ulr_pkg::ID_W-1:0]               txn_id,
    input  logic [ulr_pkg::ID_W-1:0]               item_index,
    input  logic signed [ulr_pkg::PORT_VAL_W-1:0]  write_value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   status,
    output logic signed [ulr_pkg::PORT_VAL_W-1:0]  read_value,
    output logic [ulr_pkg::PORT_CNT_W-1:0]         restored_count
);
    import ulr_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // Sequencer: decode the held request, walk the log, run the clearing sweeps.
    ulr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat_i   (dp_stat),
        .cmd_o    (dp_cmd)
    );

    // Storage, counters and response registers.
    ulr_dpath #(
        .TXN_IDS     (TXN_IDS),
        .ITEM_COUNT  (ITEM_COUNT),
        .LOG_DEPTH   (LOG_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_i          (dp_cmd),
        .stat_o         (dp_stat),
        .cmd            (cmd),
        .txn_id         (txn_id),
        .item_index     (item_index),
        .write_value    (write_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .read_value     (read_value),
        .restored_count (restored_count)
    );

endmodule

>>> src/ulr_ram.sv
// ulr_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ulr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/ulr_ctrl.sv
// ulr_ctrl: sequencer for the undo-log rollback block.
// Depends on ulr_pkg and undo_log_rollback_assert.svh; drives ulr_dpath by command struct.
`include "undo_log_rollback_assert.svh"

module ulr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ulr_pkg::dp_stat_t stat_i,
    output ulr_pkg::dp_cmd_t  cmd_o
);
    import ulr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (stat_i.sweep_last_all)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat_i.cmd == CMD_RECOVER)
                begin
                    state_next = stat_i.log_empty ? ST_REC_CLEAR : ST_REC_LOG;
                end
                else
                begin
                    state_next = stat_i.out_free ? ST_IDLE : ST_RESP;
                end
            end
            ST_REC_LOG:   state_next = ST_REC_TXN;
            ST_REC_TXN:   state_next = ST_REC_APPLY;
            ST_REC_APPLY: state_next = stat_i.rec_last ? ST_REC_CLEAR : ST_REC_LOG;
            ST_REC_CLEAR:
            begin
                if (stat_i.sweep_last_txn)
                begin
                    state_next = stat_i.out_free ? ST_IDLE : ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (stat_i.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_o    = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd_o.item_wr_clear = 1'b1;
                cmd_o.txn_wr_clear  = 1'b1;
                cmd_o.sweep_all     = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall      = 1'b0;
                cmd_o.capture = in_valid;
            end
            ST_EXEC:
            begin
                unique case (stat_i.cmd)
                    CMD_LOAD:    cmd_o.item_wr_req   = 1'b1;
                    CMD_START:   cmd_o.txn_wr_start  = !stat_i.txn_known;
                    CMD_COMMIT:  cmd_o.txn_wr_commit = 1'b1;
                    CMD_WRITE:
                    begin
                        cmd_o.log_push    = !stat_i.log_full;
                        cmd_o.item_wr_req = !stat_i.log_full;
                    end
                    CMD_RECOVER: cmd_o.rec_begin     = 1'b1;
                    default:     cmd_o.rec_begin     = 1'b0;
                endcase
                if (stat_i.cmd != CMD_RECOVER)
                begin
                    cmd_o.out_load_now = stat_i.out_free;
                    cmd_o.pend_load    = !stat_i.out_free;
                end
            end
            ST_REC_LOG:   cmd_o.rec_step = 1'b0;
            ST_REC_TXN:   cmd_o.txn_rd_log = 1'b1;
            ST_REC_APPLY:
            begin
                cmd_o.item_wr_undo = stat_i.txn_active;
                cmd_o.rec_count    = stat_i.txn_active;
                cmd_o.rec_step     = 1'b1;
            end
            ST_REC_CLEAR:
            begin
                cmd_o.txn_wr_clear = 1'b1;
                cmd_o.sweep_txn    = 1'b1;
                if (stat_i.sweep_last_txn)
                begin
                    cmd_o.out_load_now = stat_i.out_free;
                    cmd_o.pend_load    = !stat_i.out_free;
                end
            end
            ST_RESP:      cmd_o.out_load_pend = stat_i.out_free;
            default:      in_stall = 1'b1;
        endcase
    end

    `ULR_ASSERT(a_item_wr_single, $onehot0({cmd_o.item_wr_req, cmd_o.item_wr_undo, cmd_o.item_wr_clear}), "two item store writers at once")
    `ULR_ASSERT(a_result_single, $onehot0({cmd_o.out_load_now, cmd_o.out_load_pend, cmd_o.pend_load}), "result loaded twice")
    `ULR_ASSERT(a_accept_to_exec, (!in_stall && in_valid) |=> (state_reg == ST_EXEC && in_stall), "accepted request not executed")

endmodule

>>> src/ulr_dpath.sv
// ulr_dpath: item store, transaction table, undo log, counters and result registers.
// Depends on ulr_pkg, ulr_ram and undo_log_rollback_assert.svh; steered by ulr_ctrl.
`include "undo_log_rollback_assert.svh"

module ulr_dpath #(
    parameter int unsigned TXN_IDS     = ulr_pkg::TXN_IDS_DEF,
    parameter int unsigned ITEM_COUNT  = ulr_pkg::ITEM_COUNT_DEF,
    parameter int unsigned LOG_DEPTH   = ulr_pkg::LOG_DEPTH_DEF,
    parameter int unsigned VALUE_WIDTH = ulr_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ulr_pkg::dp_cmd_t                       cmd_i,
    output ulr_pkg::dp_stat_t                      stat_o,
    input  logic [ulr_pkg::CMD_W-1:0]              cmd,
    input  logic [ulr_pkg::ID_W-1:0]               txn_id,
    input  logic [ulr_pkg::ID_W-1:0]               item_index,
    input  logic signed [ulr_pkg::PORT_VAL_W-1:0]  write_value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   status,
    output logic signed [ulr_pkg::PORT_VAL_W-1:0]  read_value,
    output logic [ulr_pkg::PORT_CNT_W-1:0]         restored_count
);
    import ulr_pkg::*;

    localparam int unsigned TW        = $clog2(TXN_IDS);
    localparam int unsigned IW        = $clog2(ITEM_COUNT);
    localparam int unsigned LW        = $clog2(LOG_DEPTH);
    localparam int unsigned CW        = $clog2(LOG_DEPTH + 1);
    localparam int unsigned CLEAR_LEN = (ITEM_COUNT > TXN_IDS) ? ITEM_COUNT : TXN_IDS;
    localparam int unsigned SW        = $clog2(CLEAR_LEN);
    localparam int unsigned LOG_W     = TW + IW + VALUE_WIDTH;

    // Request registers
    logic [CMD_W-1:0]       req_cmd_reg;
    logic [TW-1:0]          req_txn_reg;
    logic [IW-1:0]          req_item_reg;
    logic [VALUE_WIDTH-1:0] req_val_reg;

    logic [TW-1:0]          port_txn;
    logic [IW-1:0]          port_item;
    logic [63:0]            port_val_wide;
    logic [VALUE_WIDTH-1:0] port_val;

    assign port_txn      = TW'(fold_index(txn_id, TXN_IDS));
    assign port_item     = IW'(fold_index(item_index, ITEM_COUNT));
    assign port_val_wide = {32'd0, write_value};
    assign port_val      = port_val_wide[VALUE_WIDTH-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd_i.capture)
        begin
            req_cmd_reg  <= cmd;
            req_txn_reg  <= port_txn;
            req_item_reg <= port_item;
            req_val_reg  <= port_val;
        end
    end

    // Counters
    logic [CW-1:0] log_count_reg;
    logic [CW-1:0] log_count_next;
    logic [LW-1:0] rec_idx_reg;
    logic [LW-1:0] rec_idx_next;
    logic [CW-1:0] restored_reg;
    logic [CW-1:0] restored_next;
    logic [SW-1:0] sweep_reg;
    logic [SW-1:0] sweep_next;
    logic [CW-1:0] newest_idx;

    logic log_full;
    logic log_empty;
    logic sweep_last_all;
    logic sweep_last_txn;
    logic sweep_in_items;
    logic sweep_in_txns;

    assign log_full       = (log_count_reg == CW'(LOG_DEPTH));
    assign log_empty      = (log_count_reg == '0);
    assign newest_idx     = log_count_reg - CW'(1);
    assign sweep_last_all = (32'(sweep_reg) == CLEAR_LEN - 1);
    assign sweep_last_txn = (32'(sweep_reg) == TXN_IDS - 1);
    assign sweep_in_items = (32'(sweep_reg) < ITEM_COUNT);
    assign sweep_in_txns  = (32'(sweep_reg) < TXN_IDS);

    always_comb
    begin
        log_count_next = log_count_reg;
        rec_idx_next   = rec_idx_reg;
        restored_next  = restored_reg;
        sweep_next     = sweep_reg;
        if (cmd_i.rec_begin)
        begin
            log_count_next = '0;
            rec_idx_next   = newest_idx[LW-1:0];
            restored_next  = '0;
        end
        if (cmd_i.log_push)
        begin
            log_count_next = log_count_reg + CW'(1);
        end
        if (cmd_i.rec_step)
        begin
            rec_idx_next = rec_idx_reg - LW'(1);
        end
        if (cmd_i.rec_count)
        begin
            restored_next = restored_reg + CW'(1);
        end
        if (cmd_i.sweep_all)
        begin
            sweep_next = sweep_last_all ? '0 : sweep_reg + SW'(1);
        end
        else if (cmd_i.sweep_txn)
        begin
            sweep_next = sweep_last_txn ? '0 : sweep_reg + SW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_count_reg <= '0;
            rec_idx_reg   <= '0;
            restored_reg  <= '0;
            sweep_reg     <= '0;
        end
        else
        begin
            log_count_reg <= log_count_next;
            rec_idx_reg   <= rec_idx_next;
            restored_reg  <= restored_next;
            sweep_reg     <= sweep_next;
        end
    end

    // Undo log
    logic [LOG_W-1:0]       log_rdata;
    logic [TW-1:0]          log_txn;
    logic [IW-1:0]          log_item;
    logic [VALUE_WIDTH-1:0] log_old;
    logic [VALUE_WIDTH-1:0] item_rdata;

    assign log_txn  = log_rdata[LOG_W-1 -: TW];
    assign log_item = log_rdata[VALUE_WIDTH +: IW];
    assign log_old  = log_rdata[VALUE_WIDTH-1:0];

    ulr_ram #(
        .WIDTH (LOG_W),
        .DEPTH (LOG_DEPTH)
    ) u_log_ram (
        .clk   (clk),
        .we    (cmd_i.log_push),
        .waddr (log_count_reg[LW-1:0]),
        .wdata ({req_txn_reg, req_item_reg, item_rdata}),
        .raddr (rec_idx_reg),
        .rdata (log_rdata)
    );

    // Item store
    logic                   item_we;
    logic [IW-1:0]          item_waddr;
    logic [VALUE_WIDTH-1:0] item_wdata;

    always_comb
    begin
        item_we    = 1'b0;
        item_waddr = req_item_reg;
        item_wdata = req_val_reg;
        if (cmd_i.item_wr_clear)
        begin
            item_we    = sweep_in_items;
            item_waddr = sweep_reg[IW-1:0];
            item_wdata = '0;
        end
        else if (cmd_i.item_wr_undo)
        begin
            item_we    = 1'b1;
            item_waddr = log_item;
            item_wdata = log_old;
        end
        else if (cmd_i.item_wr_req)
        begin
            item_we = 1'b1;
        end
    end

    ulr_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (ITEM_COUNT)
    ) u_item_ram (
        .clk   (clk),
        .we    (item_we),
        .waddr (item_waddr),
        .wdata (item_wdata),
        .raddr (port_item),
        .rdata (item_rdata)
    );

    // Transaction table: bit 1 known, bit 0 active
    logic          txn_we;
    logic [TW-1:0] txn_waddr;
    logic [1:0]    txn_wdata;
    logic [1:0]    txn_rdata;

    always_comb
    begin
        txn_we    = 1'b0;
        txn_waddr = req_txn_reg;
        txn_wdata = 2'b00;
        if (cmd_i.txn_wr_clear)
        begin
            txn_we    = sweep_in_txns;
            txn_waddr = sweep_reg[TW-1:0];
        end
        else if (cmd_i.txn_wr_start)
        begin
            txn_we    = 1'b1;
            txn_wdata = 2'b11;
        end
        else if (cmd_i.txn_wr_commit)
        begin
            txn_we    = 1'b1;
            txn_wdata = 2'b10;
        end
    end

    ulr_ram #(
        .WIDTH (2),
        .DEPTH (TXN_IDS)
    ) u_txn_ram (
        .clk   (clk),
        .we    (txn_we),
        .waddr (txn_waddr),
        .wdata (txn_wdata),
        .raddr (cmd_i.txn_rd_log ? log_txn : port_txn),
        .rdata (txn_rdata)
    );

    // Result
    logic                   res_status;
    logic [VALUE_WIDTH-1:0] res_value;
    logic [63:0]            res_value_wide;
    logic [31:0]            res_count_wide;
    logic [PORT_CNT_W-1:0]  res_count;

    assign res_status     = (req_cmd_reg == CMD_WRITE) && log_full;
    assign res_value      = ((req_cmd_reg == CMD_READ) ||
                             ((req_cmd_reg == CMD_WRITE) && !log_full)) ? item_rdata : '0;
    assign res_value_wide = 64'(res_value);
    assign res_count_wide = (req_cmd_reg == CMD_RECOVER) ? 32'(restored_reg) : 32'd0;
    assign res_count      = res_count_wide[PORT_CNT_W-1:0];

    logic                  pend_status_reg;
    logic [PORT_VAL_W-1:0] pend_value_reg;
    logic [PORT_CNT_W-1:0] pend_count_reg;
    logic                  out_status_reg;
    logic [PORT_VAL_W-1:0] out_value_reg;
    logic [PORT_CNT_W-1:0] out_count_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    always_ff @(posedge clk)
    begin
        if (cmd_i.pend_load)
        begin
            pend_status_reg <= res_status;
            pend_value_reg  <= res_value_wide[PORT_VAL_W-1:0];
            pend_count_reg  <= res_count;
        end
        if (cmd_i.out_load_now)
        begin
            out_status_reg <= res_status;
            out_value_reg  <= res_value_wide[PORT_VAL_W-1:0];
            out_count_reg  <= res_count;
        end
        else if (cmd_i.out_load_pend)
        begin
            out_status_reg <= pend_status_reg;
            out_value_reg  <= pend_value_reg;
            out_count_reg  <= pend_count_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd_i.out_load_now || cmd_i.out_load_pend)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign read_value     = out_value_reg;
    assign restored_count = out_count_reg;

    // Status back to the sequencer
    always_comb
    begin
        stat_o.cmd            = req_cmd_reg;
        stat_o.log_full       = log_full;
        stat_o.log_empty      = log_empty;
        stat_o.txn_known      = txn_rdata[1];
        stat_o.txn_active     = txn_rdata[0];
        stat_o.rec_last       = (rec_idx_reg == '0);
        stat_o.sweep_last_all = sweep_last_all;
        stat_o.sweep_last_txn = sweep_last_txn;
        stat_o.out_free       = !out_valid_reg || !out_stall;
    end

    `ULR_ASSERT(a_log_bound, log_count_reg <= CW'(LOG_DEPTH), "log count beyond depth")
    `ULR_NEVER(a_push_when_full, cmd_i.log_push && log_full, "log push into a full log")
    `ULR_ASSERT(a_rec_start_clean, cmd_i.rec_begin |=> (restored_reg == '0 && log_count_reg == '0), "recovery did not start from an empty count")

endmodule
